/* hdl/icmp_reply_checker_dup_tracker_defines.svh */
// Assertion helpers used by the checker file.
`ifndef ICMP_REPLY_CHECKER_DUP_TRACKER_DEFINES_SVH
`define ICMP_REPLY_CHECKER_DUP_TRACKER_DEFINES_SVH

// Checked only while out of reset.
`define RCDT_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked on every edge, reset included.
`define RCDT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/icmp_rcdt_pkg.sv */
package icmp_rcdt_pkg;

    // event_res codes
    localparam logic [2:0] EV_RESPONSE  = 3'd0;
    localparam logic [2:0] EV_DUPLICATE = 3'd1;
    localparam logic [2:0] EV_NOECHO    = 3'd2;
    localparam logic [2:0] EV_SHORT     = 3'd3;
    localparam logic [2:0] EV_WRONGID   = 3'd4;
    localparam logic [2:0] EV_SENT      = 3'd5;

    // ICMP reply types
    localparam logic [7:0] REPLY_TYPE_ECHO   = 8'd0;
    localparam logic [7:0] REPLY_TYPE_TSTAMP = 8'd14;
    localparam logic [7:0] REPLY_TYPE_ADDR   = 8'd18;
    localparam int unsigned MIN_ICMP_BYTES   = 8;

    typedef struct packed {
        logic        mode;
        logic [15:0] word;
        logic        last;
        logic        odd_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [15:0] seq;
        logic [7:0]  msg_type;
        logic        checksum_ok;
        logic [31:0] sent_total;
        logic [31:0] recv_total;
        logic [31:0] dup_total;
    } out_item_t;

endpackage

/* hdl/icmp_reply_checker_dup_tracker.sv */
// From input acceptance, the result reaches the m_ side through the s1 lookup
// stage (seen-table read), then the output register. Throughput: one item per
// cycle unless the output stalls or the table sweep runs; the seen table has
// one read and one write port. Reset (synchronous, active low) clears counters
// and control, then sweeps all TABLE_BITS seen-table entries to zero, one entry
// per cycle; s_ready is low during the sweep. Config writes are taken at any time.
module icmp_reply_checker_dup_tracker
    import icmp_rcdt_pkg::*;
#(
    parameter int unsigned TABLE_BITS = 128,   // power of two, 8 .. 65536
    parameter int unsigned MAX_WORDS  = 32768  // 16 .. 32768
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    localparam int unsigned IDX_W   = $clog2(TABLE_BITS);
    localparam int unsigned WI_W    = $clog2(MAX_WORDS + 1);
    localparam int unsigned BYTES_W = WI_W + 2;

    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] t;
        t = {1'b0, a} + {1'b0, b};
        return t[15:0] + {15'd0, t[16]};
    endfunction

    // ---------------------------------------------------------------- config
    logic [15:0] ident_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ident_reg <= '0;
        end else if (cfg_wr_en) begin
            ident_reg <= cfg_wr_data;
        end
    end

    // ---------------------------------------------------------------- table clear
    logic             clr_busy_reg;
    logic [IDX_W-1:0] clr_idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end else if (clr_busy_reg) begin
            clr_idx_reg  <= clr_idx_reg + 1'b1;
            clr_busy_reg <= (clr_idx_reg != {IDX_W{1'b1}});
        end
    end

    // ---------------------------------------------------------------- handshake
    logic s1_valid_reg;
    logic m_valid_reg;
    logic s1_fire;
    logic s_acc;

    assign s1_fire = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !clr_busy_reg && (!s1_valid_reg || s1_fire);
    assign s_acc   = s_valid && s_ready;

    // ---------------------------------------------------------------- packet assembly
    logic [WI_W-1:0] word_index_reg, word_index_next;
    logic [5:0]      header_bytes_reg, header_bytes_next;
    logic [15:0]     running_sum_reg, running_sum_next;
    logic [15:0]     got_checksum_reg, got_checksum_next;
    logic [7:0]      got_type_reg, got_type_next;
    logic [15:0]     got_id_reg, got_id_next;
    logic [15:0]     got_seq_reg, got_seq_next;

    logic [15:0]      w_eff;
    logic             in_range;
    logic             first;
    logic [4:0]       hw;
    logic             at_icmp;
    logic [WI_W-1:0]  k;
    logic [BYTES_W-1:0] pkt_bytes;
    logic             too_short;
    logic             reply_type;
    logic             cks_ok;

    always_comb begin
        w_eff = s_data.word;
        if (s_data.last && s_data.odd_byte) begin
            w_eff = {s_data.word[15:8], 8'h00};
        end
        in_range = (word_index_reg < WI_W'(MAX_WORDS));
        first    = (word_index_reg == '0);

        header_bytes_next = header_bytes_reg;
        running_sum_next  = running_sum_reg;
        got_checksum_next = got_checksum_reg;
        got_type_next     = got_type_reg;
        got_id_next       = got_id_reg;
        got_seq_next      = got_seq_reg;
        if (in_range && first) begin
            header_bytes_next = {w_eff[11:8], 2'b00};
            running_sum_next  = '0;
            got_checksum_next = '0;
            got_type_next     = '0;
            got_id_next       = '0;
            got_seq_next      = '0;
        end

        hw      = header_bytes_next[5:1];
        at_icmp = (word_index_reg >= WI_W'(hw));
        k       = word_index_reg - WI_W'(hw);
        if (in_range && at_icmp) begin
            if (k == WI_W'(1)) begin
                got_checksum_next = w_eff;
            end else begin
                running_sum_next = oc_add(running_sum_next, w_eff);
                if (k == WI_W'(0)) begin
                    got_type_next = w_eff[15:8];
                end else if (k == WI_W'(2)) begin
                    got_id_next = w_eff;
                end else if (k == WI_W'(3)) begin
                    got_seq_next = w_eff;
                end
            end
        end

        if (s_data.last) begin
            word_index_next = '0;
        end else if (in_range) begin
            word_index_next = word_index_reg + 1'b1;
        end else begin
            word_index_next = word_index_reg;
        end

        if (in_range) begin
            pkt_bytes = {1'b0, word_index_reg, 1'b0}
                      + (s_data.odd_byte ? BYTES_W'(1) : BYTES_W'(2));
        end else begin
            pkt_bytes = BYTES_W'(MAX_WORDS * 2);
        end
        too_short  = (pkt_bytes < (BYTES_W'(header_bytes_next) + BYTES_W'(MIN_ICMP_BYTES)));
        reply_type = (got_type_next == REPLY_TYPE_ECHO)
                  || (got_type_next == REPLY_TYPE_TSTAMP)
                  || (got_type_next == REPLY_TYPE_ADDR);
        cks_ok     = (~running_sum_next == got_checksum_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_index_reg <= '0;
        end else if (s_acc && s_data.mode) begin
            word_index_reg <= word_index_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc && s_data.mode) begin
            header_bytes_reg <= header_bytes_next;
            running_sum_reg  <= running_sum_next;
            got_checksum_reg <= got_checksum_next;
            got_type_reg     <= got_type_next;
            got_id_reg       <= got_id_next;
            got_seq_reg      <= got_seq_next;
        end
    end

    // ---------------------------------------------------------------- seen table
    logic             seen_mem [TABLE_BITS];
    logic             mem_rd_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             wr_data;

    assign rd_addr = got_seq_next[IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            seen_mem[wr_addr] <= wr_data;
        end
        if (s_acc) begin
            mem_rd_reg <= seen_mem[rd_addr];
        end
    end

    // ---------------------------------------------------------------- lookup stage
    logic             s1_tx_reg;
    logic             s1_lookup_reg;
    logic [2:0]       s1_ev_reg;
    logic [15:0]      s1_seq_reg;
    logic [7:0]       s1_type_reg;
    logic             s1_ok_reg;
    logic [IDX_W-1:0] s1_slot_reg;
    logic             s1_fwd_hit_reg;
    logic             s1_fwd_data_reg;

    logic [2:0] s0_ev;
    logic       s0_lookup;

    always_comb begin
        s0_lookup = 1'b0;
        if (too_short) begin
            s0_ev = EV_SHORT;
        end else if (!reply_type) begin
            s0_ev = EV_NOECHO;
        end else if (got_id_next != ident_reg) begin
            s0_ev = EV_WRONGID;
        end else begin
            s0_ev     = EV_RESPONSE;
            s0_lookup = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_acc) begin
            s1_valid_reg <= !s_data.mode || s_data.last;
        end else if (s1_fire) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            s1_tx_reg      <= !s_data.mode;
            s1_lookup_reg  <= s_data.mode && s0_lookup;
            s1_ev_reg      <= s_data.mode ? s0_ev : EV_SENT;
            s1_seq_reg     <= got_seq_next;
            s1_type_reg    <= s_data.mode ? got_type_next : 8'd0;
            s1_ok_reg      <= s_data.mode && !too_short && cks_ok;
            s1_slot_reg    <= rd_addr;
            // the item leaving this cycle may write the entry just read
            s1_fwd_hit_reg  <= wr_en && (wr_addr == rd_addr);
            s1_fwd_data_reg <= wr_data;
        end
    end

    logic        seen;
    logic [31:0] sent_count_reg, recv_count_reg, dup_count_reg;
    logic [31:0] sent_count_next, recv_count_next, dup_count_next;
    out_item_t   res;

    assign seen = s1_fwd_hit_reg ? s1_fwd_data_reg : mem_rd_reg;

    always_comb begin
        sent_count_next = sent_count_reg;
        recv_count_next = recv_count_reg;
        dup_count_next  = dup_count_reg;
        res.event_res   = s1_ev_reg;
        res.seq         = s1_seq_reg;
        res.msg_type    = s1_type_reg;
        res.checksum_ok = s1_ok_reg;
        if (s1_tx_reg) begin
            res.seq         = sent_count_reg[15:0];
            sent_count_next = sent_count_reg + 32'd1;
        end else if (s1_lookup_reg) begin
            if (seen) begin
                res.event_res  = EV_DUPLICATE;
                dup_count_next = dup_count_reg + 32'd1;
            end else begin
                res.event_res   = EV_RESPONSE;
                recv_count_next = recv_count_reg + 32'd1;
            end
        end
        res.sent_total = sent_count_next;
        res.recv_total = recv_count_next;
        res.dup_total  = dup_count_next;

        wr_en   = 1'b0;
        wr_addr = s1_slot_reg;
        wr_data = 1'b0;
        if (clr_busy_reg) begin
            wr_en   = 1'b1;
            wr_addr = clr_idx_reg;
        end else if (s1_fire && s1_tx_reg) begin
            wr_en   = 1'b1;
            wr_addr = sent_count_reg[IDX_W-1:0];
        end else if (s1_fire && s1_lookup_reg && !seen) begin
            wr_en   = 1'b1;
            wr_data = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sent_count_reg <= '0;
            recv_count_reg <= '0;
            dup_count_reg  <= '0;
        end else if (s1_fire) begin
            sent_count_reg <= sent_count_next;
            recv_count_reg <= recv_count_next;
            dup_count_reg  <= dup_count_next;
        end
    end

    // ---------------------------------------------------------------- output register
    out_item_t m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* hdl/icmp_rcdt_checker.sv */
`include "icmp_reply_checker_dup_tracker_defines.svh"

module icmp_rcdt_checker
    import icmp_rcdt_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    `RCDT_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data), "result item changed while stalled")

    `RCDT_ASSERT(a_out_drop, aclk, aresetn, $fell(m_valid) |-> $past(m_ready), "result item dropped without handshake")

    // reset empties the result side and starts the table sweep
    `RCDT_ASSERT_ALWAYS(a_reset_quiet, aclk, !aresetn |=> !m_valid && !s_ready, "busy right after reset")

    // transmit and too-short results carry no checksum verdict
    `RCDT_ASSERT(a_no_cks, aclk, aresetn, m_valid && (m_data.event_res == EV_SENT || m_data.event_res == EV_SHORT) |-> !m_data.checksum_ok, "checksum_ok set on sent or short item")

endmodule

bind icmp_reply_checker_dup_tracker icmp_rcdt_checker u_rcdt_checker (.*);

/* tb/tb_top.sv */
module tb_top;
    import icmp_rcdt_pkg::*;

    localparam int unsigned TBL         = 128;
    localparam int unsigned MAXW        = 32768;
    localparam int unsigned HOLD_CYCLES = 200;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned SETTLE      = 4;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    in_item_t    s_data      = '0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    out_item_t   m_data;
    logic        cfg_wr_en   = 1'b0;
    logic [15:0] cfg_wr_data = '0;

    icmp_reply_checker_dup_tracker #(
        .TABLE_BITS(TBL),
        .MAX_WORDS (MAXW)
    ) uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ---------------- reply tracker model ----------------
    logic [15:0] ident_cfg = '0;
    bit          seen_tbl[TBL];
    logic [31:0] tx_count  = '0;
    logic [31:0] rx_count  = '0;
    logic [31:0] dup_count = '0;
    int unsigned widx      = 0;
    logic [5:0]  hdr_len   = '0;
    logic [15:0] csum      = '0;
    logic [15:0] got_ck    = '0;
    logic [7:0]  got_ty    = '0;
    logic [15:0] got_id    = '0;
    logic [15:0] got_sq    = '0;

    out_item_t   reply_q[$];

    function automatic logic [15:0] ones_add(logic [15:0] a, logic [15:0] b);
        logic [16:0] t;
        t = {1'b0, a} + {1'b0, b};
        return t[15:0] + {15'd0, t[16]};
    endfunction

    function automatic void predict_item(in_item_t it);
        out_item_t   r;
        logic [15:0] w;
        logic [15:0] calc;
        int unsigned entry;
        int unsigned hw;
        int unsigned k;
        int unsigned nbytes;
        r = '0;
        if (it.mode == 1'b0) begin
            r.event_res = EV_SENT;
            r.seq = tx_count[15:0];
            seen_tbl[tx_count % TBL] = 1'b0;
            tx_count = tx_count + 1;
            r.sent_total = tx_count;
            r.recv_total = rx_count;
            r.dup_total = dup_count;
            reply_q.push_back(r);
            return;
        end
        w = it.word;
        if (it.last && it.odd_byte) w[7:0] = 8'h00;
        entry = widx;
        if (entry < MAXW) begin
            if (entry == 0) begin
                hdr_len = {w[11:8], 2'b00};
                csum = '0;
                got_ck = '0;
                got_ty = '0;
                got_id = '0;
                got_sq = '0;
            end
            hw = 32'(hdr_len) >> 1;
            if (entry >= hw) begin
                k = entry - hw;
                if (k == 1) begin
                    got_ck = w;
                end else begin
                    csum = ones_add(csum, w);
                    if (k == 0) got_ty = w[15:8];
                    else if (k == 2) got_id = w;
                    else if (k == 3) got_sq = w;
                end
            end
            widx = entry + 1;
        end
        if (!it.last) return;
        nbytes = (entry < MAXW) ? entry * 2 + (it.odd_byte ? 1 : 2) : MAXW * 2;
        widx = 0;
        r.seq = got_sq;
        r.msg_type = got_ty;
        if (nbytes < 32'(hdr_len) + 8) begin
            r.event_res = EV_SHORT;
        end else begin
            calc = ~csum;
            r.checksum_ok = (calc == got_ck);
            if (got_ty == REPLY_TYPE_ECHO || got_ty == REPLY_TYPE_TSTAMP ||
                got_ty == REPLY_TYPE_ADDR) begin
                if (got_id != ident_cfg) begin
                    r.event_res = EV_WRONGID;
                end else if (seen_tbl[got_sq % TBL]) begin
                    dup_count = dup_count + 1;
                    r.event_res = EV_DUPLICATE;
                end else begin
                    seen_tbl[got_sq % TBL] = 1'b1;
                    rx_count = rx_count + 1;
                    r.event_res = EV_RESPONSE;
                end
            end else begin
                r.event_res = EV_NOECHO;
            end
        end
        r.sent_total = tx_count;
        r.recv_total = rx_count;
        r.dup_total = dup_count;
        reply_q.push_back(r);
    endfunction

    // ---------------- result checking ----------------
    int        err_cnt = 0;
    int        ev_seen[8];
    int        ck_bad_seen = 0;
    out_item_t rx_want;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        err_cnt++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (reply_q.size() == 0) begin
                report_mismatch($sformatf("result with nothing pending, event %0d",
                                          m_data.event_res));
            end else begin
                rx_want = reply_q.pop_front();
                check_field("event_res", 32'(m_data.event_res), 32'(rx_want.event_res));
                check_field("seq", 32'(m_data.seq), 32'(rx_want.seq));
                check_field("msg_type", 32'(m_data.msg_type), 32'(rx_want.msg_type));
                check_field("checksum_ok", 32'(m_data.checksum_ok),
                            32'(rx_want.checksum_ok));
                check_field("sent_total", m_data.sent_total, rx_want.sent_total);
                check_field("recv_total", m_data.recv_total, rx_want.recv_total);
                check_field("dup_total", m_data.dup_total, rx_want.dup_total);
                ev_seen[rx_want.event_res]++;
                if (rx_want.event_res != EV_SENT && rx_want.event_res != EV_SHORT &&
                    !rx_want.checksum_ok)
                    ck_bad_seen++;
            end
        end
    end

    // watchdog: cycles with no item moving on either side
    int unsigned quiet_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Timeout after %0d stalled cycles, %0d replies pending",
                         quiet_cycles, reply_q.size());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // ---------------- receiver side ----------------
    bit idle_on   = 1'b1;
    int idle_pct  = 20;
    int stall_pct = 20;
    bit hold_req  = 1'b0;

    initial begin
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 99) < stall_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // ---------------- sender side ----------------
    int          items_sent = 0;
    int          pkts_sent  = 0;
    int          cfg_writes = 0;
    logic [15:0] pkt[$];
    logic [15:0] last_seq = '0;

    task automatic send_item(input in_item_t it);
        if (idle_on && $urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_item(it);
        items_sent++;
    endtask

    task automatic send_tx();
        in_item_t it;
        it.mode     = 1'b0;
        it.word     = 16'($urandom);
        it.last     = 1'($urandom);
        it.odd_byte = 1'($urandom);
        send_item(it);
    endtask

    // lets the block empty out; nothing is offered meanwhile
    task automatic drain();
        s_valid <= 1'b0;
        while (reply_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_ident(input logic [15:0] v);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        ident_cfg = v;
        cfg_writes++;
    endtask

    // IP header (ihl 32-bit words) followed by an ICMP echo-style message
    task automatic build_pkt(input int ihl, input logic [7:0] ty, input logic [15:0] id,
                             input logic [15:0] sq, input int npay, input bit odd,
                             input bit bad_ck);
        logic [15:0] pw;
        logic [15:0] s;
        int          hw;
        hw = ihl * 2;
        pkt.delete();
        for (int i = 0; i < hw; i++) begin
            pw = 16'($urandom);
            if (i == 0) pw[11:8] = ihl[3:0];
            pkt.push_back(pw);
        end
        if (ihl == 0) ty[3:0] = 4'h0;
        pw = {ty, 8'($urandom)};
        if (ihl == 0) pw[11:8] = 4'h0;
        pkt.push_back(pw);
        pkt.push_back(16'h0000);
        pkt.push_back(id);
        pkt.push_back(sq);
        for (int i = 0; i < npay; i++) pkt.push_back(16'($urandom));
        if (odd) pkt[pkt.size() - 1][7:0] = 8'h00;
        s = '0;
        for (int i = hw; i < pkt.size(); i++) s = ones_add(s, pkt[i]);
        pkt[hw + 1] = bad_ck ? ~s ^ 16'($urandom_range(1, 65535)) : ~s;
    endtask

    task automatic send_packet(input bit odd, input bit tx_mix);
        in_item_t it;
        for (int i = 0; i < pkt.size(); i++) begin
            if (tx_mix && $urandom_range(0, 9) == 0) send_tx();
            it.mode     = 1'b1;
            it.word     = pkt[i];
            it.last     = (i == pkt.size() - 1);
            // odd flag off the last word is don't-care
            it.odd_byte = it.last ? odd : 1'($urandom);
            if (it.last && odd) it.word[7:0] = 8'($urandom);
            send_item(it);
        end
        pkts_sent++;
    endtask

    function automatic logic [15:0] pick_seq();
        int unsigned r;
        int unsigned back;
        r = $urandom_range(0, 99);
        if (tx_count == 0 || r < 15) return 16'($urandom);
        if (r < 35) return last_seq;
        back = (tx_count - 1 < 140) ? tx_count - 1 : 140;
        return 16'(tx_count - 1 - $urandom_range(0, back));
    endfunction

    task automatic send_random_reply(input bit trunc);
        int          ihl;
        logic [7:0]  ty;
        logic [15:0] id;
        logic [15:0] sq;
        int          npay;
        int          keep;
        bit          odd;
        int unsigned r;
        ihl = ($urandom_range(0, 9) < 7) ? 5 : $urandom_range(0, 15);
        r = $urandom_range(0, 99);
        ty = (r < 60) ? REPLY_TYPE_ECHO : (r < 70) ? REPLY_TYPE_TSTAMP :
             (r < 80) ? REPLY_TYPE_ADDR : 8'($urandom);
        id = ($urandom_range(0, 99) < 85) ? ident_cfg : 16'($urandom);
        sq = pick_seq();
        npay = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
        odd = ($urandom_range(0, 3) == 0);
        build_pkt(ihl, ty, id, sq, npay, odd, $urandom_range(0, 6) == 0);
        if (trunc) begin
            keep = $urandom_range(1, ihl * 2 + 3);
            while (pkt.size() > keep) void'(pkt.pop_back());
        end
        send_packet(odd, $urandom_range(0, 4) == 0);
        last_seq = sq;
    endtask

    task automatic send_noise();
        in_item_t it;
        int       n;
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) begin
            it.mode     = 1'b1;
            it.word     = 16'($urandom);
            it.last     = (i == n - 1) || ($urandom_range(0, 3) == 0);
            it.odd_byte = 1'($urandom);
            send_item(it);
        end
    endtask

    task automatic random_traffic(input int n_items);
        int target;
        int sel;
        target = items_sent + n_items;
        while (items_sent < target) begin
            if (idle_on) begin
                sel = $urandom_range(0, 2);
                idle_pct  = (sel == 0) ? 0 : (sel == 1) ? 10 : 40;
                stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
            end
            sel = $urandom_range(0, 99);
            if (sel < 20) repeat ($urandom_range(1, 4)) send_tx();
            else if (sel < 80) send_random_reply(1'b0);
            else if (sel < 90) send_random_reply(1'b1);
            else send_noise();
        end
    endtask

    // ---------------- tests ----------------
    task automatic test_directed();
        in_item_t it;
        it = '0;
        it.word = 16'hffff;
        send_item(it);
        it.word = 16'h0000;
        it.last = 1'b1;
        it.odd_byte = 1'b1;
        send_item(it);
        // ident is 0 after reset; zero header length puts ICMP at word 0
        build_pkt(0, REPLY_TYPE_ECHO, 16'h0000, 16'h0000, 0, 1'b0, 1'b0);
        send_packet(1'b0, 1'b0);
        send_packet(1'b0, 1'b0);                       // same seq again: duplicate
        build_pkt(0, REPLY_TYPE_ECHO, 16'hffff, 16'h0001, 0, 1'b0, 1'b1);
        send_packet(1'b0, 1'b0);                       // wrong id, bad checksum
        build_pkt(0, 8'h80, 16'h0000, 16'hffff, 0, 1'b0, 1'b0);
        send_packet(1'b0, 1'b0);                       // not a reply type
        build_pkt(0, REPLY_TYPE_ECHO, 16'h0000, 16'h0001, 0, 1'b0, 1'b0);
        void'(pkt.pop_back());
        void'(pkt.pop_back());
        send_packet(1'b0, 1'b0);                       // too short
        build_pkt(0, REPLY_TYPE_ECHO, 16'h0000, 16'h0001, 1, 1'b1, 1'b0);
        send_packet(1'b1, 1'b0);                       // odd length reply
        drain();
    endtask

    task automatic test_ident_max();
        set_ident(16'hffff);
        repeat (3) send_tx();
        build_pkt(5, REPLY_TYPE_TSTAMP, 16'hffff, 16'(tx_count - 1), 3, 1'b0, 1'b0);
        send_packet(1'b0, 1'b1);
        build_pkt(5, REPLY_TYPE_ADDR, 16'hffff, 16'(tx_count - 2), 2, 1'b1, 1'b0);
        send_packet(1'b1, 1'b1);
        build_pkt(15, REPLY_TYPE_ECHO, 16'hffff, 16'(tx_count - 3), 4, 1'b0, 1'b0);
        send_packet(1'b0, 1'b1);
        build_pkt(5, REPLY_TYPE_ECHO, 16'h0000, 16'(tx_count - 3), 0, 1'b0, 1'b0);
        send_packet(1'b0, 1'b0);
        drain();
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        repeat (40) send_tx();
        repeat (4) send_random_reply(1'b0);
        while (hold_req) @(posedge aclk);
        drain();
    endtask

    task automatic test_random();
        random_traffic(250);
        set_ident(16'($urandom));
        random_traffic(250);
        set_ident(16'h0000);
        random_traffic(250);
        drain();
    endtask

    task automatic test_no_idle();
        set_ident(16'h5a5a);
        idle_on = 1'b0;
        random_traffic(200);
        drain();
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_ident_max();
        test_backpressure();
        test_random();
        test_no_idle();
        repeat (8) @(posedge aclk);
        $display("Ran %0d items: %0d packets, %0d transmits, %0d ident writes",
                 items_sent, pkts_sent, ev_seen[EV_SENT], cfg_writes);
        $display("Results: resp %0d dup %0d noecho %0d short %0d wrongid %0d ck_bad %0d",
                 ev_seen[EV_RESPONSE], ev_seen[EV_DUPLICATE], ev_seen[EV_NOECHO],
                 ev_seen[EV_SHORT], ev_seen[EV_WRONGID], ck_bad_seen);
        if (err_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches", err_cnt);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hdl
hdl/icmp_rcdt_pkg.sv
hdl/icmp_reply_checker_dup_tracker.sv
hdl/icmp_rcdt_checker.sv
tb/tb_top.sv
